[hdl/grid_wavefront_distance_map_defines.svh]
// ----------------------------------------------------------------------------
// Grid wavefront distance map: assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_WAVEFRONT_DISTANCE_MAP_DEFINES_SVH
`define GRID_WAVEFRONT_DISTANCE_MAP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define GWD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define GWD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GWD_ASSERT_IMP(lbl, ante, cons, msg)
`define GWD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/gwd_pkg.sv]
// ----------------------------------------------------------------------------
// gwd_pkg
// Shared types, codes and constants of the grid wavefront distance map.
// ----------------------------------------------------------------------------
package gwd_pkg;

  // Grid size default and fixed field widths
  localparam int GRID_SIZE_DEF = 16;
  localparam int COORD_W       = 4;
  localparam int SWEEP_W       = 6;
  localparam int DIST_W        = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;

  // Register reset values
  localparam logic [SWEEP_W-1:0] SWEEP_RESET = 6'd15;
  localparam logic [DIST_W-1:0]  INIT_RESET  = 8'd81;
  localparam logic [DIST_W-1:0]  WALL_RESET  = 8'd99;
  localparam logic [DIST_W-1:0]  DIST_MAX    = 8'd255;

  // Operation codes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2
  } gwd_op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_ROW  = 3'd0,
    REG_GOAL_COL  = 3'd1,
    REG_SWEEP_CNT = 3'd2,
    REG_INIT_DIST = 3'd3,
    REG_WALL_MARK = 3'd4
  } gwd_reg_e;

  // Channel payloads
  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               is_wall;
  } gwd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              cell_blocked;
  } gwd_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic rd_in;       // read cell at input address
    logic wr_load;     // write loaded cell
    logic latch_kind;  // capture transaction kind
    logic cnt_clear;   // reset sweep counters
    logic rd_ud;       // read up and down neighbors
    logic rd_rc;       // read right neighbor and center
    logic update;      // relax current cell
    logic cnt_step;    // advance to next cell
    logic out_load;    // move result into output register
  } gwd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_grid;     // input address lies on the grid
    logic run_zero;    // sweep count is zero
    logic run_last;    // last cell of last sweep
    logic out_free;    // output register can take a result
  } gwd_stat_t;

endpackage

[hdl/gwd_stream_if.sv]
// ----------------------------------------------------------------------------
// gwd_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface gwd_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

[hdl/gwd_ctrl.sv]
// ----------------------------------------------------------------------------
// gwd_ctrl
// Sequencer: decodes transactions and steps the datapath through sweeps.
// ----------------------------------------------------------------------------
module gwd_ctrl
  import gwd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [1:0] in_op_i,
  output logic      in_ready_o,
  input  gwd_stat_t stat_i,
  output gwd_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RD_UD  = 6'b000010,
    S_RD_RC  = 6'b000100,
    S_UPDATE = 6'b001000,
    S_DONE   = 6'b010000,
    S_SPARE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch_kind = 1'b1;
          state_d          = S_DONE;
          case (gwd_op_e'(in_op_i))
            OP_LOAD: cmd_o.wr_load = stat_i.in_grid;
            OP_READ: cmd_o.rd_in   = 1'b1;
            OP_RUN: begin
              if (!stat_i.run_zero) begin
                cmd_o.cnt_clear = 1'b1;
                state_d         = S_RD_UD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_UD: begin
        cmd_o.rd_ud = 1'b1;
        state_d     = S_RD_RC;
      end
      S_RD_RC: begin
        cmd_o.rd_rc = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (stat_i.run_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.cnt_step = 1'b1;
          state_d        = S_RD_UD;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/gwd_datapath.sv]
// ----------------------------------------------------------------------------
// gwd_datapath
// Configuration registers, cell memory, sweep counters, relaxation logic
// and the output register.
// ----------------------------------------------------------------------------
module gwd_datapath
  import gwd_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  gwd_in_t               in_payload_i,
  input  logic                  out_ready_i,
  input  gwd_cmd_t              cmd_i,
  output gwd_stat_t             stat_o,
  output logic                  out_valid_o,
  output gwd_out_t              out_payload_o
);

  localparam int ROW_W  = $clog2(GRID_SIZE);
  localparam int ADDR_W = 2 * ROW_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CMP_W  = (ROW_W + 1 > COORD_W) ? ROW_W + 1 : COORD_W;
  localparam logic [ROW_W-1:0] LAST = ROW_W'(GRID_SIZE - 1);

  // Two-input minimum over usable neighbors: {found, value}
  function automatic logic [DIST_W:0] pick_min(
    input logic              va,
    input logic [DIST_W-1:0] a,
    input logic              vb,
    input logic [DIST_W-1:0] b
  );
    logic [DIST_W:0] res;
    if (va && (!vb || a <= b)) begin
      res = {1'b1, a};
    end else if (vb) begin
      res = {1'b1, b};
    end else begin
      res = '0;
    end
    return res;
  endfunction

  // Configuration registers
  logic [COORD_W-1:0] goal_row_q, goal_col_q;
  logic [SWEEP_W-1:0] sweep_count_q;
  logic [DIST_W-1:0]  init_dist_q, wall_mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_row_q    <= '0;
      goal_col_q    <= '0;
      sweep_count_q <= SWEEP_RESET;
      init_dist_q   <= INIT_RESET;
      wall_mark_q   <= WALL_RESET;
    end else if (cfg_we_i) begin
      case (gwd_reg_e'(cfg_index_i))
        REG_GOAL_ROW:  goal_row_q    <= cfg_data_i[COORD_W-1:0];
        REG_GOAL_COL:  goal_col_q    <= cfg_data_i[COORD_W-1:0];
        REG_SWEEP_CNT: sweep_count_q <= cfg_data_i[SWEEP_W-1:0];
        REG_INIT_DIST: init_dist_q   <= cfg_data_i[DIST_W-1:0];
        REG_WALL_MARK: wall_mark_q   <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Input address decode
  logic [CMP_W-1:0]  in_row_ext, in_col_ext;
  logic [ADDR_W-1:0] in_addr;
  logic              in_grid, in_goal;

  assign in_row_ext = CMP_W'(in_payload_i.cell_row);
  assign in_col_ext = CMP_W'(in_payload_i.cell_col);
  assign in_grid    = (in_row_ext < CMP_W'(GRID_SIZE)) && (in_col_ext < CMP_W'(GRID_SIZE));
  assign in_addr    = {in_row_ext[ROW_W-1:0], in_col_ext[ROW_W-1:0]};
  assign in_goal    = (in_payload_i.cell_row == goal_row_q) &&
                      (in_payload_i.cell_col == goal_col_q);

  // Sweep position counters
  logic [ROW_W-1:0]   r_q, c_q;
  logic [SWEEP_W-1:0] sweep_q;
  logic               last_cell, last_sweep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q     <= '0;
      c_q     <= '0;
      sweep_q <= '0;
    end else if (cmd_i.cnt_clear) begin
      r_q     <= '0;
      c_q     <= '0;
      sweep_q <= '0;
    end else if (cmd_i.cnt_step) begin
      if (c_q == LAST) begin
        c_q <= '0;
        if (r_q == LAST) begin
          r_q     <= '0;
          sweep_q <= sweep_q + SWEEP_W'(1);
        end else begin
          r_q <= r_q + ROW_W'(1);
        end
      end else begin
        c_q <= c_q + ROW_W'(1);
      end
    end
  end

  assign last_cell  = (r_q == LAST) && (c_q == LAST);
  assign last_sweep = (sweep_q == sweep_count_q - SWEEP_W'(1));

  // Neighbor addresses
  logic [ROW_W-1:0]  r_up, r_dn, c_rt;
  logic [ADDR_W-1:0] ctr_addr;

  assign r_up     = r_q - ROW_W'(1);
  assign r_dn     = r_q + ROW_W'(1);
  assign c_rt     = c_q + ROW_W'(1);
  assign ctr_addr = {r_q, c_q};

  // Cell memory: one write port, two registered read ports
  logic [DIST_W-1:0] mem_q [DEPTH];
  logic [DIST_W-1:0] rdata_a_q, rdata_b_q;
  logic [ADDR_W-1:0] raddr_a, raddr_b, waddr;
  logic [DIST_W-1:0] wdata;
  logic              we;

  always_comb begin
    raddr_a = in_addr;
    raddr_b = ctr_addr;
    if (cmd_i.rd_ud) begin
      raddr_a = {r_up, c_q};
      raddr_b = {r_dn, c_q};
    end else if (cmd_i.rd_rc) begin
      raddr_a = {r_q, c_rt};
      raddr_b = ctr_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_in || cmd_i.rd_ud || cmd_i.rd_rc) begin
      rdata_a_q <= mem_q[raddr_a];
    end
    if (cmd_i.rd_ud || cmd_i.rd_rc) begin
      rdata_b_q <= mem_q[raddr_b];
    end
  end

  // Neighbor holding registers
  logic [DIST_W-1:0] up_q, dn_q, left_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_rc) begin
      up_q <= rdata_a_q;
      dn_q <= rdata_b_q;
    end
  end

  // Relaxation of the current cell
  logic [DIST_W-1:0] center, right;
  logic              use_up, use_dn, use_lf, use_rt, ctr_wall, ctr_goal;
  logic [DIST_W:0]   min_ul, min_rd, min_all;
  logic [DIST_W-1:0] relaxed;

  assign right    = rdata_a_q;
  assign center   = rdata_b_q;
  assign ctr_wall = (center == wall_mark_q);
  assign ctr_goal = (CMP_W'(r_q) == CMP_W'(goal_row_q)) && (CMP_W'(c_q) == CMP_W'(goal_col_q));
  assign use_up   = (r_q != '0) && (up_q != wall_mark_q);
  assign use_dn   = (r_q != LAST) && (dn_q != wall_mark_q);
  assign use_lf   = (c_q != '0) && (left_q != wall_mark_q);
  assign use_rt   = (c_q != LAST) && (right != wall_mark_q);
  assign min_ul   = pick_min(use_up, up_q, use_lf, left_q);
  assign min_rd   = pick_min(use_rt, right, use_dn, dn_q);
  assign min_all  = pick_min(min_ul[DIST_W], min_ul[DIST_W-1:0],
                             min_rd[DIST_W], min_rd[DIST_W-1:0]);

  always_comb begin
    if (ctr_goal) begin
      relaxed = '0;
    end else if (!min_all[DIST_W]) begin
      relaxed = wall_mark_q;
    end else if (min_all[DIST_W-1:0] == DIST_MAX) begin
      relaxed = DIST_MAX;
    end else begin
      relaxed = min_all[DIST_W-1:0] + DIST_W'(1);
    end
  end

  // Left neighbor of the next cell is this cell's final value
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      left_q <= ctr_wall ? center : relaxed;
    end
  end

  // Write port select
  always_comb begin
    if (cmd_i.wr_load) begin
      we    = 1'b1;
      waddr = in_addr;
      if (in_goal) begin
        wdata = '0;
      end else begin
        wdata = in_payload_i.is_wall ? wall_mark_q : init_dist_q;
      end
    end else begin
      we    = cmd_i.update && !ctr_wall;
      waddr = ctr_addr;
      wdata = relaxed;
    end
  end

  // Transaction kind and output register
  logic     is_read_q;
  logic     out_valid_q;
  gwd_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_kind) begin
      is_read_q <= (gwd_op_e'(in_payload_i.op) == OP_READ) && in_grid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.distance     <= is_read_q ? rdata_a_q : '0;
      out_q.cell_blocked <= is_read_q && (rdata_a_q == wall_mark_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

  // Status
  assign stat_o.in_grid  = in_grid;
  assign stat_o.run_zero = (sweep_count_q == '0);
  assign stat_o.run_last = last_cell && last_sweep;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

[hdl/grid_wavefront_distance_map.sv]
// ----------------------------------------------------------------------------
// grid_wavefront_distance_map
// Wavefront distance map over a square grid for path planning.
// ----------------------------------------------------------------------------
// Usage: in_i takes one transaction at a time (op, cell_row, cell_col,
// is_wall); out_o returns exactly one result per input transaction, in order.
// Load writes one cell (wall mark, initial distance, or 0 for the goal).
// Run performs sweep_count in-place raster relaxation sweeps. Read returns
// the cell value and whether it equals the wall mark; other ops return zeros.
// A load, read or unused op passes from S_IDLE through S_DONE, and out_o.valid
// rises once the output register takes its result.
// A run steps through each cell of each sweep in turn: up/down reads, then
// right/center reads, then relax and write back on the two-read-port cell
// memory; its result then goes through S_DONE to the output register.
// in_i.ready is high only while no transaction is in progress. A finished
// result sits in the output register; the next transaction can be taken
// while it waits, and a further result holds until out_o is drained.
// Reset clears control state and the configuration registers to their defaults; the cell
// memory is not cleared, so every cell must be loaded before runs or reads.
// Configuration writes go through cfg_we_i / cfg_index_i / cfg_data_i.
// ----------------------------------------------------------------------------
`include "grid_wavefront_distance_map_defines.svh"

module grid_wavefront_distance_map
  import gwd_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gwd_stream_if.sink            in_i,
  gwd_stream_if.source          out_o
);

  gwd_cmd_t  cmd;
  gwd_stat_t stat;
  gwd_in_t   in_payload;
  gwd_out_t  out_payload;
  logic      in_ready;
  logic      out_valid;

  assign in_payload    = in_i.payload;
  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_payload;

  // Sequencer
  gwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_payload.op),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Registers, cell memory and relaxation datapath
  gwd_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_payload_i  (in_payload),
    .out_ready_i   (out_o.ready),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid),
    .out_payload_o (out_payload)
  );

  // Checks
  `GWD_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_ready, !in_ready, "ready after accept")
  `GWD_ASSERT_NXT(a_ud_then_rc, cmd.rd_ud, cmd.rd_rc, "read sequence broken")
  `GWD_ASSERT_NXT(a_rc_then_update, cmd.rd_rc, cmd.update, "update missing after reads")
  `GWD_ASSERT_IMP(a_valid_from_load, $rose(out_valid), $past(cmd.out_load), "stray result")

endmodule
